/* rtl/mdvd_pkg.sv */
package mdvd_pkg;

    localparam int CODE_W  = 32;
    localparam int COORD_W = 16;

    localparam logic [2:0] HEADER_BYTES = 3'd4;
    localparam logic [5:0] GROUP_BITS   = 6'd7;
    localparam logic [5:0] SHIFT_LIMIT  = 6'd32;

    typedef struct packed {
        logic [2:0]        header_count;
        logic [CODE_W-1:0] accumulator;
        logic [5:0]        group_shift;
        logic [CODE_W-1:0] previous_code;
    } t_state;

    typedef struct packed {
        logic              emit;
        logic [CODE_W-1:0] code;
    } t_result;

    function automatic logic [COORD_W-1:0] f_even_bits(input logic [CODE_W-1:0] v);
        logic [COORD_W-1:0] r;
        r = '0;
        for (int k = 0; k < COORD_W; k++) begin
            r[k] = v[2*k];
        end
        return r;
    endfunction

endpackage

/* rtl/morton_delta_varint_decoder.sv */
// Morton delta varint decoder.
// Input channel: i_valid / o_stall carry one stream byte (i_code_byte) per
// item; i_stream_start marks the first byte of a new stream and clears the
// decode state before that byte is used.
// Output channel: o_valid / i_stall carry one point (o_point_x, o_point_y)
// for every completed Morton code: the fourth header byte, and every delta
// byte with bit 0 set.
// An item is taken at a rising edge with valid high and stall low.
// A byte is held in the input register; its decode plus 32-bit add then loads
// the point into the output register, which drives o_valid.
// Throughput: one byte per cycle while the output is not stalled.
// When i_stall holds a point, the decode stage waits and the input register
// keeps one byte; o_stall rises once that register is full and cannot move.
// Reset (i_rst_n low, synchronous) empties both registers and clears the
// decode state, so the next bytes are read as a header.
module morton_delta_varint_decoder
    import mdvd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_code_byte,
    input  logic               i_stream_start,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [COORD_W-1:0] o_point_x,
    output logic [COORD_W-1:0] o_point_y
);

    logic               r_in_valid;
    logic [7:0]         r_in_byte;
    logic               r_in_start;
    t_state             r_state;
    t_state             n_state;
    t_result            step_res;
    logic               r_out_valid;
    logic [COORD_W-1:0] r_out_x;
    logic [COORD_W-1:0] r_out_y;
    logic               out_free;
    logic               advance;
    logic               in_take;

    mdvd_decode u_decode (
        .i_byte   (r_in_byte),
        .i_start  (r_in_start),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (step_res)
    );

    assign out_free = !r_out_valid || !i_stall;
    assign advance  = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;
    assign in_take  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_state     <= n_state;
                r_out_valid <= step_res.emit;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte  <= i_code_byte;
            r_in_start <= i_stream_start;
        end
        if (advance && step_res.emit) begin
            r_out_x <= f_even_bits(step_res.code);
            r_out_y <= f_even_bits(step_res.code >> 1);
        end
    end

    assign o_valid   = r_out_valid;
    assign o_point_x = r_out_x;
    assign o_point_y = r_out_y;

`ifndef SYNTHESIS
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid && !o_stall)
        else $error("output not empty after reset");

    a_header_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.header_count <= HEADER_BYTES)
        else $error("header count out of range");

    a_shift_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.group_shift == 6'd0 || r_state.group_shift == 6'd7 ||
        r_state.group_shift == 6'd14 || r_state.group_shift == 6'd21 ||
        r_state.group_shift == 6'd28 || r_state.group_shift == 6'd35)
        else $error("group shift off the 7-bit grid");

    a_stall_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_in_valid && o_valid && i_stall)
        else $error("input stalled without a held point");

    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_state))
        else $error("decode state moved without an item");
`endif

endmodule

/* rtl/mdvd_decode.sv */
module mdvd_decode
    import mdvd_pkg::*;
(
    input  logic [7:0] i_byte,
    input  logic       i_start,
    input  t_state     i_state,
    output t_state     o_state,
    output t_result    o_result
);

    t_state            s;
    logic [CODE_W-1:0] hdr_acc;
    logic [38:0]       grp_wide;
    logic [CODE_W-1:0] grp_bits;
    logic [CODE_W-1:0] delta;
    logic [2:0]        hdr_next;

    always_comb begin
        s        = i_start ? '0 : i_state;
        hdr_acc  = s.accumulator
                 | (CODE_W'(i_byte) << {s.header_count[1:0], 3'b000});
        grp_wide = {32'd0, i_byte[7:1]} << s.group_shift;
        grp_bits = (s.group_shift < SHIFT_LIMIT) ? grp_wide[CODE_W-1:0] : '0;
        delta    = s.accumulator | grp_bits;
        hdr_next = s.header_count + 3'd1;

        o_state       = s;
        o_result.emit = 1'b0;
        o_result.code = s.previous_code;

        if (s.header_count < HEADER_BYTES) begin
            o_state.header_count = hdr_next;
            if (hdr_next == HEADER_BYTES) begin
                o_state.previous_code = hdr_acc;
                o_state.accumulator   = '0;
                o_state.group_shift   = '0;
                o_result.emit         = 1'b1;
                o_result.code         = hdr_acc;
            end else begin
                o_state.accumulator = hdr_acc;
            end
        end else if (i_byte[0]) begin
            o_state.previous_code = s.previous_code + delta;
            o_state.accumulator   = '0;
            o_state.group_shift   = '0;
            o_result.emit         = 1'b1;
            o_result.code         = s.previous_code + delta;
        end else begin
            o_state.accumulator = delta;
            if (s.group_shift < SHIFT_LIMIT) begin
                o_state.group_shift = s.group_shift + GROUP_BITS;
            end
        end
    end

endmodule

/* sim/testbench.sv */
module testbench
    import mdvd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } t_point;

    typedef struct packed {
        logic [7:0]         b;
        logic               s;
        bit                 typed;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } t_stim_row;

    localparam int NUM_DIR  = 23;
    localparam int HOLD_LEN = 300;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [7:0]         i_code_byte;
    logic               i_stream_start;
    logic               o_valid;
    logic               i_stall;
    logic [COORD_W-1:0] o_point_x;
    logic [COORD_W-1:0] o_point_y;

    morton_delta_varint_decoder dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_code_byte    (i_code_byte),
        .i_stream_start (i_stream_start),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_point_x      (o_point_x),
        .o_point_y      (o_point_y)
    );

    // decoder state mirror
    logic [2:0]        dec_hdr_cnt;
    logic [CODE_W-1:0] dec_acc;
    logic [5:0]        dec_shift;
    logic [CODE_W-1:0] dec_prev;

    t_point pending_points[$];
    int     fail_cnt     = 0;
    int     items_sent   = 0;
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    int     hold_reqs    = 0;

    t_stim_row dir_rows [NUM_DIR] = '{
        // no start after reset: read as header
        '{8'hFF, 1'b0, 1'b0, 16'h0000, 16'h0000},
        '{8'hFF, 1'b0, 1'b0, 16'h0000, 16'h0000},
        '{8'hFF, 1'b0, 1'b0, 16'h0000, 16'h0000},
        '{8'hFF, 1'b0, 1'b1, 16'hFFFF, 16'hFFFF},
        // zero delta, then +1 wraps to zero
        '{8'h01, 1'b0, 1'b1, 16'hFFFF, 16'hFFFF},
        '{8'h03, 1'b0, 1'b1, 16'h0000, 16'h0000},
        '{8'h55, 1'b1, 1'b0, 16'h0000, 16'h0000},
        '{8'h55, 1'b0, 1'b0, 16'h0000, 16'h0000},
        '{8'h55, 1'b0, 1'b0, 16'h0000, 16'h0000},
        '{8'h55, 1'b0, 1'b1, 16'hFFFF, 16'h0000},
        // long delta, groups past bit 31 dropped
        '{8'hFE, 1'b0, 1'b0, 16'h0000, 16'h0000},
        '{8'hFE, 1'b0, 1'b0, 16'h0000, 16'h0000},
        '{8'hFE, 1'b0, 1'b0, 16'h0000, 16'h0000},
        '{8'hFE, 1'b0, 1'b0, 16'h0000, 16'h0000},
        '{8'hFE, 1'b0, 1'b0, 16'h0000, 16'h0000},
        '{8'hFE, 1'b0, 1'b0, 16'h0000, 16'h0000},
        '{8'hFF, 1'b0, 1'b0, 16'h0000, 16'h0000},
        // restart inside a delta, then inside a header
        '{8'h80, 1'b0, 1'b0, 16'h0000, 16'h0000},
        '{8'h12, 1'b1, 1'b0, 16'h0000, 16'h0000},
        '{8'h34, 1'b1, 1'b0, 16'h0000, 16'h0000},
        '{8'h00, 1'b0, 1'b0, 16'h0000, 16'h0000},
        '{8'h00, 1'b0, 1'b0, 16'h0000, 16'h0000},
        '{8'h81, 1'b0, 1'b0, 16'h0000, 16'h0000}
    };

    function automatic logic [COORD_W-1:0] gather_even(input logic [CODE_W-1:0] v);
        logic [COORD_W-1:0] r;
        for (int k = 0; k < COORD_W; k++) begin
            r[k] = v[2*k];
        end
        return r;
    endfunction

    function automatic void queue_point(input t_point p);
        pending_points = {pending_points, p};
    endfunction

    function automatic void clear_decoder();
        dec_hdr_cnt = '0;
        dec_acc     = '0;
        dec_shift   = '0;
        dec_prev    = '0;
    endfunction

    // returns 1 when the byte completes a code
    function automatic bit decode_byte(input logic [7:0] b, input logic s);
        if (s) begin
            clear_decoder();
        end
        if (dec_hdr_cnt < HEADER_BYTES) begin
            dec_acc     = dec_acc | ({24'd0, b} << (int'(dec_hdr_cnt) * 8));
            dec_hdr_cnt = dec_hdr_cnt + 3'd1;
            if (dec_hdr_cnt == HEADER_BYTES) begin
                dec_prev  = dec_acc;
                dec_acc   = '0;
                dec_shift = '0;
                return 1'b1;
            end
            return 1'b0;
        end
        if (dec_shift < SHIFT_LIMIT) begin
            dec_acc = dec_acc | ({25'd0, b[7:1]} << dec_shift);
        end
        if (b[0]) begin
            dec_prev  = dec_prev + dec_acc;
            dec_acc   = '0;
            dec_shift = '0;
            return 1'b1;
        end
        if (dec_shift < SHIFT_LIMIT) begin
            dec_shift = dec_shift + GROUP_BITS;
        end
        return 1'b0;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic s, input bit typed,
                             input t_point want);
        bit emit;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_code_byte    <= b;
        i_stream_start <= s;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        items_sent++;
        emit = decode_byte(b, s);
        if (typed) begin
            queue_point(want);
        end else if (emit) begin
            queue_point('{gather_even(dec_prev), gather_even(dec_prev >> 1)});
        end
    endtask

    task automatic send_rand(input logic [7:0] b, input logic s);
        send_byte(b, s, 1'b0, '0);
    endtask

    // one stream: header then deltas; a few are broken or pure noise
    task automatic send_stream();
        int n_deltas;
        int len;
        if ($urandom_range(99) < 10) begin
            repeat ($urandom_range(1, 12)) begin
                send_rand(8'($urandom), $urandom_range(99) < 10);
            end
            return;
        end
        send_rand(8'($urandom), 1'b1);
        repeat (3) begin
            send_rand(8'($urandom), $urandom_range(99) < 3);
        end
        n_deltas = $urandom_range(1, 12);
        repeat (n_deltas) begin
            len = ($urandom_range(99) < 10) ? $urandom_range(6, 9) : $urandom_range(1, 5);
            for (int i = 0; i < len - 1; i++) begin
                send_rand({7'($urandom), 1'b0}, 1'b0);
            end
            if ($urandom_range(99) < 4) begin
                return;
            end
            send_rand({7'($urandom), 1'b1}, 1'b0);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("morton_delta_varint_decoder test failed");
        $finish;
    end

    // receiver: random stall, plus long hold-offs on request
    initial begin
        int hold_left;
        int holds_served;
        hold_left    = 0;
        holds_served = 0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (holds_served != hold_reqs) begin
                holds_served = hold_reqs;
                hold_left    = HOLD_LEN;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_point want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_points.size() == 0) begin
                fail_cnt++;
                if (fail_cnt <= 10) begin
                    $display("unexpected point x=%h y=%h", o_point_x, o_point_y);
                end
            end else begin
                want = pending_points.pop_front();
                if (o_point_x !== want.x || o_point_y !== want.y) begin
                    fail_cnt++;
                    if (fail_cnt <= 10) begin
                        $display("point mismatch: expected x=%h y=%h, got x=%h y=%h",
                                 want.x, want.y, o_point_x, o_point_y);
                    end
                end
            end
        end
    end

    initial begin
        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_code_byte    <= '0;
        i_stream_start <= 1'b0;
        clear_decoder();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 28;
        recv_idle_pct = 63;
        for (int i = 0; i < NUM_DIR; i++) begin
            send_byte(dir_rows[i].b, dir_rows[i].s, dir_rows[i].typed,
                      '{dir_rows[i].x, dir_rows[i].y});
        end

        while (items_sent < 450) begin
            send_stream();
        end
        send_idle_pct = 63;
        recv_idle_pct = 28;
        while (items_sent < 890) begin
            send_stream();
        end
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_reqs++;
        while (items_sent < 1330) begin
            send_stream();
        end
        i_valid <= 1'b0;

        while (pending_points.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("morton_delta_varint_decoder test passed");
        end else begin
            $display("morton_delta_varint_decoder test failed");
        end
        $finish;
    end

endmodule
